[sv/timed_event_queue_defines.svh]
// ---------------------------------------------------------------------------
// Timed event queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timed_event_queue: assertion failed");

// Consequent sequence starts in the cycle after the antecedent.
`define TQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> cons) \
    else $error("timed_event_queue: assertion failed");

`endif

[sv/tq_pkg.sv]
// ---------------------------------------------------------------------------
// Timed event queue package
// Operation and result codes, stored entry layout and compare result type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tq_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kinds and add status codes.
  localparam logic RK_STATUS = 1'b0;
  localparam logic RK_EVENT  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_FULL   = 1'b1;

  // Most events released by one tick, and the width of that count.
  localparam int MAX_RESULTS = 32;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  // Event data carried through the queue unchanged.
  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  kind;
    logic        ai;
    logic [15:0] owner;
    logic [23:0] delay;
  } payload_t;

  // One stored queue entry.
  typedef struct packed {
    logic [31:0] wake;
    payload_t    pay;
  } entry_t;

  // Outcome of the shared wrap-aware time compare.
  typedef struct packed {
    logic later;
    logic due;
  } cmp_t;

endpackage

[sv/timed_event_queue.sv]
// ---------------------------------------------------------------------------
// Timed event queue
// Timer event scheduler holding events sorted by wake time in a ring memory.
// ---------------------------------------------------------------------------
// Usage: raise start with operation and the event fields; the transaction is
// taken at a rising edge where start is high and busy is low. An add places
// the event in wake-time order (now + delay_ms) and answers with one status
// result: accepted, or full with the event dropped. A tick advances the
// millisecond counter by one and releases every due event, earliest first,
// up to 32 per tick, the final one marked by last_o. A tick with nothing due
// gives no result and busy simply falls.
// Each result is shown for one cycle with result_valid_o; the receiver cannot
// stall, so no back-pressure exists. Results are registered and appear in the
// cycle after the work that produced them, while busy may already be low.
// Steps: an add walks back from the tail, moving each stored entry later
// than the new one up by one slot, then writes the new entry into the hole;
// a full queue goes straight to its status. A tick reads and compares the
// head entry until one is not due, the queue empties or the per-tick limit
// is reached. Every compare step costs one read of the single memory read
// port plus one pass through the shared time comparator.
// Reset clears the queue and the millisecond counter; no clearing pass runs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_event_queue_defines.svh"

module timed_event_queue
  import tq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [15:0] event_id_i,
  input  logic [23:0] delay_ms_i,
  input  logic [3:0]  event_kind_i,
  input  logic        ai_flag_i,
  input  logic [15:0] owner_id_i,
  output logic        result_valid_o,
  output logic        result_kind_o,
  output logic        status_o,
  output logic [15:0] due_id_o,
  output logic [3:0]  due_kind_o,
  output logic        due_ai_o,
  output logic [15:0] due_owner_o,
  output logic [23:0] due_delay_o,
  output logic        last_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_ACK     = 3'd3;
  localparam logic [2:0] S_TK_RD   = 3'd4;
  localparam logic [2:0] S_TK_CMP  = 3'd5;

  // Ring pointer steps with wrap at the queue depth.
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [31:0]   now_q, now_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] hole_ptr_q, hole_ptr_d;
  logic [CW-1:0] hole_cnt_q, hole_cnt_d;
  logic [NW-1:0] n_q, n_d;
  logic          op_q, op_d;
  logic          full_q, full_d;
  entry_t        new_q, new_d;
  payload_t      pend_q, pend_d;
  logic          pend_vld_q, pend_vld_d;
  logic          res_vld_q, res_vld_d;
  logic          res_kind_q, res_kind_d;
  logic          res_status_q, res_status_d;
  payload_t      res_pay_q, res_pay_d;
  logic          res_last_q, res_last_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic [31:0]   cmp_ref;
  cmp_t          cmp_res;

  // Entry memory.
  tq_store #(
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared comparator: against the new wake time for adds, the clock for ticks.
  assign cmp_ref = (op_q == OP_TICK) ? now_q : new_q.wake;

  tq_cmp u_cmp (
    .stored_i (mem_rdata.wake),
    .ref_i    (cmp_ref),
    .res_o    (cmp_res)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    count_d      = count_q;
    head_d       = head_q;
    tail_d       = tail_q;
    hole_ptr_d   = hole_ptr_q;
    hole_cnt_d   = hole_cnt_q;
    n_d          = n_q;
    op_d         = op_q;
    full_d       = full_q;
    new_d        = new_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    res_vld_d    = 1'b0;
    res_kind_d   = res_kind_q;
    res_status_d = res_status_q;
    res_pay_d    = res_pay_q;
    res_last_d   = res_last_q;
    mem_we       = 1'b0;
    mem_waddr    = hole_ptr_q;
    mem_wdata    = new_q;
    mem_raddr    = head_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = operation_i;
          if (operation_i == OP_ADD) begin
            new_d.wake      = now_q + {8'd0, delay_ms_i};
            new_d.pay.id    = event_id_i;
            new_d.pay.kind  = event_kind_i;
            new_d.pay.ai    = ai_flag_i;
            new_d.pay.owner = owner_id_i;
            new_d.pay.delay = delay_ms_i;
            full_d          = (count_q == CW'(QUEUE_DEPTH));
            hole_ptr_d      = tail_q;
            hole_cnt_d      = count_q;
            state_d         = (count_q == CW'(QUEUE_DEPTH)) ? S_ACK : S_INS_RD;
          end else begin
            now_d      = now_q + 32'd1;
            n_d        = '0;
            pend_vld_d = 1'b0;
            state_d    = S_TK_RD;
          end
        end
      end

      // Walk back from the tail, moving later entries up by one slot.
      S_INS_RD: begin
        if (hole_cnt_q == '0) begin
          mem_we  = 1'b1;
          state_d = S_ACK;
        end else begin
          mem_raddr = ptr_dec(hole_ptr_q);
          state_d   = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp_res.later) begin
          mem_wdata  = mem_rdata;
          hole_ptr_d = ptr_dec(hole_ptr_q);
          hole_cnt_d = hole_cnt_q - 1'b1;
          state_d    = S_INS_RD;
        end else begin
          state_d = S_ACK;
        end
      end

      // Status result of an add.
      S_ACK: begin
        res_vld_d    = 1'b1;
        res_kind_d   = RK_STATUS;
        res_status_d = full_q ? ST_FULL : ST_OK;
        res_pay_d    = '0;
        res_last_d   = 1'b1;
        if (!full_q) begin
          count_d = count_q + 1'b1;
          tail_d  = ptr_inc(tail_q);
        end
        state_d = S_IDLE;
      end

      // Read the head entry unless the queue is empty or the tick is at its limit.
      S_TK_RD: begin
        if ((count_q == '0) || (n_q == NW'(MAX_RESULTS))) begin
          if (pend_vld_q) begin
            res_vld_d    = 1'b1;
            res_kind_d   = RK_EVENT;
            res_status_d = ST_OK;
            res_pay_d    = pend_q;
            res_last_d   = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          mem_raddr = head_q;
          state_d   = S_TK_CMP;
        end
      end

      // A due head is held back one step so that the final one can be marked.
      S_TK_CMP: begin
        if (pend_vld_q) begin
          res_vld_d    = 1'b1;
          res_kind_d   = RK_EVENT;
          res_status_d = ST_OK;
          res_pay_d    = pend_q;
          res_last_d   = !cmp_res.due;
        end
        if (cmp_res.due) begin
          pend_d     = mem_rdata.pay;
          pend_vld_d = 1'b1;
          head_d     = ptr_inc(head_q);
          count_d    = count_q - 1'b1;
          n_d        = n_q + 1'b1;
          state_d    = S_TK_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      now_q      <= '0;
      count_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      now_q      <= now_d;
      count_q    <= count_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    hole_ptr_q   <= hole_ptr_d;
    hole_cnt_q   <= hole_cnt_d;
    n_q          <= n_d;
    op_q         <= op_d;
    full_q       <= full_d;
    new_q        <= new_d;
    pend_q       <= pend_d;
    res_kind_q   <= res_kind_d;
    res_status_q <= res_status_d;
    res_pay_q    <= res_pay_d;
    res_last_q   <= res_last_d;
  end

  // Result ports.
  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_kind_o  = res_kind_q;
  assign status_o       = res_status_q;
  assign due_id_o       = res_pay_q.id;
  assign due_kind_o     = res_pay_q.kind;
  assign due_ai_o       = res_pay_q.ai;
  assign due_owner_o    = res_pay_q.owner;
  assign due_delay_o    = res_pay_q.delay;
  assign last_o         = res_last_q;

  // The fill count never passes the depth.
  `TQ_ASSERT_SAME(a_count_range, 1'b1, count_q <= CW'(QUEUE_DEPTH))
  // A result only follows a cycle of sequencer work.
  `TQ_ASSERT_SAME(a_result_after_work, result_valid_o, $past(state_q) != S_IDLE)
  // An add status is always the final result of its transaction.
  `TQ_ASSERT_SAME(a_status_is_last, result_valid_o && (result_kind_o == RK_STATUS), last_o)
  // An add into a full queue is answered as dropped without touching the store.
  `TQ_ASSERT_NEXT(a_full_drop, start && !busy && (operation_i == OP_ADD) && (count_q == CW'(QUEUE_DEPTH)), ##1 (result_valid_o && (status_o == ST_FULL)))

endmodule

[sv/tq_store.sv]
// ---------------------------------------------------------------------------
// Timed event queue entry store
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tq_store
  import tq_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write and registered read in one clocked block.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/tq_cmp.sv]
// ---------------------------------------------------------------------------
// Timed event queue time compare
// Shared 32-bit subtractor giving the wrap-aware later and due decisions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tq_cmp
  import tq_pkg::*;
(
  input  logic [31:0] stored_i,
  input  logic [31:0] ref_i,
  output cmp_t        res_o
);

  logic [31:0] diff;

  // The signed difference decides both relations.
  assign diff       = stored_i - ref_i;
  assign res_o.later = (diff != 32'd0) && !diff[31];
  assign res_o.due   = (diff == 32'd0) || diff[31];

endmodule

[verif/timed_event_queue_test.sv]
// ---------------------------------------------------------------------------
// Timed event queue testbench
// Drives add and tick transactions with random idle gaps, predicts every add
// status and every released event from a private copy of the sorted queue,
// and checks each strobed result field by field against the oldest one due.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_event_queue_test;
  import tq_pkg::*;

  localparam int QDEPTH       = 32;
  localparam int RANDOM_ITEMS = 210;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 8;

  // One result as seen on the output ports.
  typedef struct packed {
    logic     kind;
    logic     status;
    payload_t pay;
    logic     last;
  } queue_result_t;

  // Scoreboard: keeps its own sorted event queue and the results still owed.
  class queue_scoreboard;
    logic [31:0]   wake_q [QDEPTH];
    payload_t      pay_q  [QDEPTH];
    int unsigned   count;
    logic [31:0]   clock_ms;
    queue_result_t owed_results [$];
    int            errors;

    function new();
      count    = 0;
      clock_ms = '0;
      errors   = 0;
    endfunction

    // Wrap-aware order: a is strictly later than b.
    function automatic bit is_later(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != '0) && !d[31];
    endfunction

    // Wrap-aware due test: the wake time is now or already past.
    function automatic bit is_due(logic [31:0] wake, logic [31:0] now);
      logic [31:0] d;
      d = wake - now;
      return (d == '0) || d[31];
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Updates the queue copy for one accepted transaction and records the
    // results that it owes.
    function void note_item(logic op, payload_t item);
      queue_result_t res;
      logic [31:0]   wake;
      int unsigned   pos;
      int unsigned   n;
      res = '0;
      if (op == OP_ADD) begin
        res.kind = RK_STATUS;
        res.last = 1'b1;
        if (count >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.status = ST_OK;
          wake = clock_ms + {8'd0, item.delay};
          pos  = 0;
          while (pos < count && !is_later(wake_q[pos], wake)) pos++;
          for (int unsigned i = count; i > pos; i--) begin
            wake_q[i] = wake_q[i - 1];
            pay_q[i]  = pay_q[i - 1];
          end
          wake_q[pos] = wake;
          pay_q[pos]  = item;
          count++;
        end
        owed_results.push_back(res);
      end else begin
        clock_ms = clock_ms + 32'd1;
        n = 0;
        while (n < count && n < MAX_RESULTS && is_due(wake_q[n], clock_ms)) n++;
        for (int unsigned i = 0; i < n; i++) begin
          res.kind   = RK_EVENT;
          res.status = ST_OK;
          res.pay    = pay_q[i];
          res.last   = (i == n - 1);
          owed_results.push_back(res);
        end
        for (int unsigned i = n; i < count; i++) begin
          wake_q[i - n] = wake_q[i];
          pay_q[i - n]  = pay_q[i];
        end
        count -= n;
      end
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Checks one strobed result against the oldest owed one.
    function void check_result(queue_result_t got);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare("result_kind", 32'(want.kind), 32'(got.kind));
      compare("status", 32'(want.status), 32'(got.status));
      compare("due_id", 32'(want.pay.id), 32'(got.pay.id));
      compare("due_kind", 32'(want.pay.kind), 32'(got.pay.kind));
      compare("due_ai", 32'(want.pay.ai), 32'(got.pay.ai));
      compare("due_owner", 32'(want.pay.owner), 32'(got.pay.owner));
      compare("due_delay", 32'(want.pay.delay), 32'(got.pay.delay));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction

    function void check_leftovers();
      if (owed_results.size() != 0) begin
        $display("%0t: results missing: expected %0d more, actual 0",
                 $time, owed_results.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        busy;
  logic        operation_i  = OP_TICK;
  logic [15:0] event_id_i   = '0;
  logic [23:0] delay_ms_i   = '0;
  logic [3:0]  event_kind_i = '0;
  logic        ai_flag_i    = 1'b0;
  logic [15:0] owner_id_i   = '0;
  logic        result_valid_o;
  logic        result_kind_o;
  logic        status_o;
  logic [15:0] due_id_o;
  logic [3:0]  due_kind_o;
  logic        due_ai_o;
  logic [15:0] due_owner_o;
  logic [23:0] due_delay_o;
  logic        last_o;

  queue_scoreboard sb = new();
  int              items_sent = 0;
  int              calm_left  = 0;

  timed_event_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .event_id_i     (event_id_i),
    .delay_ms_i     (delay_ms_i),
    .event_kind_i   (event_kind_i),
    .ai_flag_i      (ai_flag_i),
    .owner_id_i     (owner_id_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .status_o       (status_o),
    .due_id_o       (due_id_o),
    .due_kind_o     (due_kind_o),
    .due_ai_o       (due_ai_o),
    .due_owner_o    (due_owner_o),
    .due_delay_o    (due_delay_o),
    .last_o         (last_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run length.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin : result_monitor
    queue_result_t got;
    if (rst_ni && result_valid_o) begin
      got.kind      = result_kind_o;
      got.status    = status_o;
      got.pay.id    = due_id_o;
      got.pay.kind  = due_kind_o;
      got.pay.ai    = due_ai_o;
      got.pay.owner = due_owner_o;
      got.pay.delay = due_delay_o;
      got.last      = last_o;
      sb.check_result(got);
    end
  end

  // Idle gap before a transaction: mostly none or short, a few long, and
  // now and then a stretch of back-to-back transactions.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 5) begin
      calm_left = $urandom_range(5, 20);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Delays are mostly short so that events come due during the run; a few
  // span the whole field.
  function automatic logic [23:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 24'($urandom_range(0, 3));
    if (r < 96) return 24'($urandom_range(4, 40));
    return 24'($urandom);
  endfunction

  // Drives one transaction and waits until the block takes it. Called just
  // after a rising edge; start is left high for a following transaction.
  task automatic send_item(logic op, logic [15:0] id, logic [23:0] delay,
                           logic [3:0] kind, logic ai, logic [15:0] owner);
    int       gap;
    payload_t item;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    event_id_i   <= id;
    delay_ms_i   <= delay;
    event_kind_i <= kind;
    ai_flag_i    <= ai;
    owner_id_i   <= owner;
    do @(posedge clk_i); while (busy);
    item.id    = id;
    item.kind  = kind;
    item.ai    = ai;
    item.owner = owner;
    item.delay = delay;
    sb.note_item(op, item);
    items_sent++;
  endtask

  task automatic send_add(logic [23:0] delay);
    send_item(OP_ADD, 16'($urandom), delay, 4'($urandom), 1'($urandom), 16'($urandom));
  endtask

  // The event fields of a tick are ignored, so they carry random noise.
  task automatic send_tick();
    send_item(OP_TICK, 16'($urandom), 24'($urandom), 4'($urandom), 1'($urandom),
              16'($urandom));
  endtask

  initial begin : stimulus
    int r;
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a tick on an empty queue releases nothing.
    send_tick();
    // Extreme field values, both due on the next tick; equal wake times
    // must leave in insertion order.
    send_item(OP_ADD, 16'hFFFF, 24'd0, 4'hF, 1'b1, 16'hFFFF);
    send_item(OP_ADD, 16'h0000, 24'd0, 4'h0, 1'b0, 16'h0000);
    send_tick();
    // The largest delay stays queued for the whole run.
    send_item(OP_ADD, 16'h5A5A, 24'hFFFFFF, 4'hA, 1'b0, 16'hA5A5);
    // A tie group, a later event, then one more of the tie group, which
    // must slot in behind the group and ahead of the later event.
    for (int k = 0; k < 4; k++) send_add(24'd1);
    send_add(24'd2);
    send_add(24'd1);
    send_tick();
    send_tick();
    send_tick();
    // Out-of-order delays and a mid-range long one.
    send_add(24'd3);
    send_add(24'd0);
    send_add(24'h800000);
    send_tick();
    send_tick();
    send_tick();

    // Random: first fill the queue past its depth so that full statuses
    // are seen, then mix single transactions, add bursts and tick runs.
    n = QDEPTH - int'(sb.count) + 3;
    for (int k = 0; k < n; k++) send_add(24'($urandom_range(0, 63)));
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 1) == 0) send_add(pick_delay());
        else send_tick();
      end else if (r < 60) begin
        n = $urandom_range(3, 12);
        for (int k = 0; k < n; k++) send_add(pick_delay());
      end else if (r < 66) begin
        n = QDEPTH - int'(sb.count) + $urandom_range(1, 3);
        for (int k = 0; k < n; k++) send_add(24'($urandom_range(0, 40)));
      end else begin
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) send_tick();
      end
    end
    start <= 1'b0;

    // Let every owed result arrive, then allow the block to settle.
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/tq_pkg.sv
sv/tq_store.sv
sv/tq_cmp.sv
sv/timed_event_queue.sv
verif/timed_event_queue_test.sv
